// File: design/epvm_pkg.sv
package epvm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW = 32;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;
  localparam int MW = CW + DW;
  localparam int SW = MW + 2;
  localparam int DVW = SW + 1;
  localparam int TW = SW + FRAC_BITS + 2;
  localparam int QB = DW + 1;
  localparam int RW = DVW + QB + 1;

  typedef struct packed {
    logic                   degen;
    logic [2:0]             neg;
    logic [DVW-1:0]         dv;
    logic [2:0][TW-1:0]     top;
  } prep_t;

  typedef struct packed {
    logic                   degen;
    logic [2:0]             neg;
    logic [2:0]             ovf;
    logic [DVW-1:0]         dv;
    logic [2:0][RW-1:0]     rem;
    logic [2:0][QB-1:0]     q;
  } div_t;

endpackage

// File: design/eye_position_from_view_matrix_core.sv
// Computes the camera eye position as the meeting point of the three planes
// held in the top rows of a view matrix, in signed Q16.16 with rounding to
// nearest and saturation; a zero determinant gives zero coordinates and sets
// the degenerate flag. A new request is taken in every cycle while no stall
// holds the pipeline, and each result passes through six stages of products
// and sums followed by a 33-step restoring quotient pipeline with an output
// register. Empty stages close up when the output is stalled.
module eye_position_from_view_matrix_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // row0_x, row0_y, row0_z, row0_dist, row1_x, row1_y, row1_z, row1_dist,
  // row2_x, row2_y, row2_z, row2_dist
  input  logic [383:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // eye_x, eye_y, eye_z
  output logic [95:0]  m_tdata,
  // degenerate
  output logic [0:0]   m_tuser
);

  localparam int DW  = epvm_pkg::DW;
  localparam int PW  = epvm_pkg::PW;
  localparam int CW  = epvm_pkg::CW;
  localparam int MW  = epvm_pkg::MW;
  localparam int SW  = epvm_pkg::SW;
  localparam int TW  = epvm_pkg::TW;
  localparam int DVW = epvm_pkg::DVW;

  logic signed [DW-1:0] nin [3][3];
  logic signed [DW-1:0] din [3];

  for (genvar R = 0; R < 3; R++) begin : g_in
    for (genvar C = 0; C < 3; C++) begin : g_col
      assign nin[R][C] = s_tdata[DW*(R*4+C) +: DW];
    end
    assign din[R] = s_tdata[DW*(R*4+3) +: DW];
  end

  logic v [1:6];
  logic e [1:7];
  logic q_ready;

  always_comb begin
    e[7] = q_ready;
    for (int s = 6; s >= 1; s--) begin
      e[s] = !v[s] || e[s+1];
    end
  end

  assign s_tready = e[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= 6; s++) v[s] <= 1'b0;
    end else begin
      if (e[1]) v[1] <= s_tvalid;
      for (int s = 2; s <= 6; s++) begin
        if (e[s]) v[s] <= v[s-1];
      end
    end
  end

  logic signed [PW-1:0] f1_pa [3][3];
  logic signed [PW-1:0] f1_pb [3][3];
  logic signed [DW-1:0] f1_d  [3];
  logic signed [DW-1:0] f1_n0 [3];

  for (genvar J = 0; J < 3; J++) begin : g_cross
    localparam int U = (J + 1) % 3;
    localparam int W = (J + 2) % 3;
    for (genvar K = 0; K < 3; K++) begin : g_comp
      localparam int I1 = (K + 1) % 3;
      localparam int I2 = (K + 2) % 3;
      always_ff @(posedge clk) begin
        if (e[1]) begin
          f1_pa[J][K] <= nin[U][I1] * nin[W][I2];
          f1_pb[J][K] <= nin[U][I2] * nin[W][I1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e[1]) begin
      for (int r = 0; r < 3; r++) begin
        f1_d[r]  <= din[r];
        f1_n0[r] <= nin[0][r];
      end
    end
  end

  logic signed [CW-1:0] f2_c  [3][3];
  logic signed [DW-1:0] f2_d  [3];
  logic signed [DW-1:0] f2_n0 [3];

  always_ff @(posedge clk) begin
    if (e[2]) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          f2_c[j][k] <= CW'(f1_pa[j][k]) - CW'(f1_pb[j][k]);
        end
        f2_d[j]  <= f1_d[j];
        f2_n0[j] <= f1_n0[j];
      end
    end
  end

  // Rows 0 to 2 are the numerator terms, row 3 the determinant terms.
  logic signed [CW-1:0] f3_lo [4][3];
  logic signed [CW-1:0] f3_hi [4][3];

  always_ff @(posedge clk) begin
    if (e[3]) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          f3_lo[j][k] <= $signed({1'b0, f2_c[j][k][DW-1:0]}) * f2_d[j];
          f3_hi[j][k] <= $signed(f2_c[j][k][CW-1:DW]) * f2_d[j];
        end
      end
      for (int k = 0; k < 3; k++) begin
        f3_lo[3][k] <= $signed({1'b0, f2_c[0][k][DW-1:0]}) * f2_n0[k];
        f3_hi[3][k] <= $signed(f2_c[0][k][CW-1:DW]) * f2_n0[k];
      end
    end
  end

  logic signed [MW-1:0] f4_m [4][3];

  always_ff @(posedge clk) begin
    if (e[4]) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 3; k++) begin
          f4_m[j][k] <= (MW'(f3_hi[j][k]) <<< DW) + MW'(f3_lo[j][k]);
        end
      end
    end
  end

  logic signed [SW-1:0] f5_num [3];
  logic signed [SW-1:0] f5_den;

  always_ff @(posedge clk) begin
    if (e[5]) begin
      for (int k = 0; k < 3; k++) begin
        f5_num[k] <= SW'(f4_m[0][k]) + SW'(f4_m[1][k]) + SW'(f4_m[2][k]);
      end
      f5_den <= SW'(f4_m[3][0]) + SW'(f4_m[3][1]) + SW'(f4_m[3][2]);
    end
  end

  epvm_pkg::prep_t prep_next;
  epvm_pkg::prep_t f6_prep;
  logic [SW-1:0]   an [3];
  logic [SW-1:0]   ad;

  always_comb begin
    ad = f5_den[SW-1] ? SW'(-f5_den) : f5_den;
    prep_next.degen = f5_den == '0;
    prep_next.dv    = {ad, 1'b0};
    for (int k = 0; k < 3; k++) begin
      an[k] = f5_num[k][SW-1] ? SW'(-f5_num[k]) : f5_num[k];
      prep_next.top[k] = (TW'(an[k]) << (epvm_pkg::FRAC_BITS + 1)) + TW'(ad);
      prep_next.neg[k] = (f5_num[k] != '0) && (f5_num[k][SW-1] == f5_den[SW-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (e[6]) f6_prep <= prep_next;
  end

  logic [2:0][DW-1:0] eye;
  logic               degen;

  epvm_quot u_quot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v[6]),
    .in_ready  (q_ready),
    .in_data   (f6_prep),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_eye   (eye),
    .out_degen (degen)
  );

  assign m_tdata = {eye[2], eye[1], eye[0]};
  assign m_tuser = degen;

endmodule

// File: design/epvm_quot.sv
module epvm_quot (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  epvm_pkg::prep_t            in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0][epvm_pkg::DW-1:0] out_eye,
  output logic                       out_degen
);

  localparam int QB = epvm_pkg::QB;
  localparam int RW = epvm_pkg::RW;
  localparam int DW = epvm_pkg::DW;

  epvm_pkg::div_t st  [QB+1];
  epvm_pkg::div_t nxt [QB+1];
  logic           v   [QB+1];
  logic           en  [QB+2];

  always_comb begin
    en[QB+1] = !out_valid || out_ready;
    for (int k = QB; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_comb begin
    nxt[0].degen = in_data.degen;
    nxt[0].neg   = in_data.neg;
    nxt[0].dv    = in_data.dv;
    for (int c = 0; c < 3; c++) begin
      nxt[0].rem[c] = RW'(in_data.top[c]);
      nxt[0].ovf[c] = RW'(in_data.top[c]) >= (RW'(in_data.dv) << QB);
      nxt[0].q[c]   = '0;
    end
  end

  for (genvar K = 1; K <= QB; K++) begin : g_step
    logic [RW-1:0] sub;
    always_comb begin
      sub = RW'(st[K-1].dv) << (QB - K);
      nxt[K] = st[K-1];
      for (int c = 0; c < 3; c++) begin
        if (st[K-1].rem[c] >= sub) begin
          nxt[K].rem[c] = st[K-1].rem[c] - sub;
          nxt[K].q[c]   = {st[K-1].q[c][QB-2:0], 1'b1};
        end else begin
          nxt[K].q[c]   = {st[K-1].q[c][QB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QB; k++) v[k] <= 1'b0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k <= QB; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= QB; k++) begin
      if (en[k]) st[k] <= nxt[k];
    end
  end

  logic [2:0][DW-1:0] eye_next;
  logic [QB-1:0]      qneg [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qneg[c] = QB'(0) - st[QB].q[c];
      if (st[QB].degen) begin
        eye_next[c] = '0;
      end else if (st[QB].neg[c]) begin
        if (st[QB].ovf[c] || st[QB].q[c] > QB'(64'h80000000)) begin
          eye_next[c] = {1'b1, {(DW-1){1'b0}}};
        end else begin
          eye_next[c] = qneg[c][DW-1:0];
        end
      end else begin
        if (st[QB].ovf[c] || st[QB].q[c][QB-1:DW-1] != '0) begin
          eye_next[c] = {1'b0, {(DW-1){1'b1}}};
        end else begin
          eye_next[c] = st[QB].q[c][DW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en[QB+1]) begin
      out_valid <= v[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en[QB+1]) begin
      out_eye   <= eye_next;
      out_degen <= st[QB].degen;
    end
  end

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_degen |-> out_eye == '0)
    else $error("degenerate result with nonzero coordinates");
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v[0])
    else $error("accepted request lost at first stage");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    v[QB] && en[QB+1] |=> out_valid)
    else $error("last stage did not reach the output register");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_eye))
    else $error("stalled result changed");
`endif

endmodule
